@@ rtl/fdtd_pkg.sv @@
`default_nettype none

package fdtd_pkg;

  localparam int OP_WIDTH = 2;

  typedef logic [OP_WIDTH-1:0] op_t;

  localparam op_t OP_DZ = 2'd0;
  localparam op_t OP_EZ = 2'd1;
  localparam op_t OP_HX = 2'd2;
  localparam op_t OP_HY = 2'd3;

endpackage

`default_nettype wire

@@ rtl/fdtd_if.sv @@
`default_nettype none

interface fdtd_in_if
  import fdtd_pkg::*;
#(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  op_t                          operation;
  logic signed [DATA_WIDTH-1:0] value_old;
  logic signed [DATA_WIDTH-1:0] integral_old;
  logic signed [DATA_WIDTH-1:0] neighbor_a;
  logic signed [DATA_WIDTH-1:0] neighbor_b;
  logic signed [DATA_WIDTH-1:0] neighbor_c;
  logic signed [DATA_WIDTH-1:0] neighbor_d;
  logic signed [DATA_WIDTH-1:0] coef_a;
  logic signed [DATA_WIDTH-1:0] coef_b;
  logic signed [DATA_WIDTH-1:0] coef_c;
  logic signed [DATA_WIDTH-1:0] coef_d;

  modport source (
    output valid, operation, value_old, integral_old, neighbor_a, neighbor_b,
           neighbor_c, neighbor_d, coef_a, coef_b, coef_c, coef_d,
    input  ready
  );

  modport sink (
    input  valid, operation, value_old, integral_old, neighbor_a, neighbor_b,
           neighbor_c, neighbor_d, coef_a, coef_b, coef_c, coef_d,
    output ready
  );
endinterface

interface fdtd_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] field_new;
  logic signed [DATA_WIDTH-1:0] integral_new;
  logic                         saturated;

  modport source (
    output valid, field_new, integral_new, saturated,
    input  ready
  );

  modport sink (
    input  valid, field_new, integral_new, saturated,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/fdtd_tmz_pml_cell_update.sv @@
`default_nettype none

// Channel  | Direction | Payload
// ---------+-----------+-------------------------------------------------------
// in_ch    | sink      | operation, value_old, integral_old, neighbor_a..d,
//          |           | coef_a..d
// out_ch   | source    | field_new, integral_new, saturated
//
// Five register stages; an item enters every cycle unless a stalled output
// has backed up to the input. The two multiplier stages
// (two and four) set the cycle time. Reset clears only the stage valid bits.
// Each stage moves forward when it is empty or the next one moves, so bubbles
// close up and a stalled output holds its item without loss or repetition.

module fdtd_tmz_pml_cell_update
  import fdtd_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  wire               clk,
  input  wire               rst_n,
  fdtd_in_if.sink           in_ch,
  fdtd_out_if.source        out_ch
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;
  localparam int WW = (2 * DATA_WIDTH + 2 > FRAC_BITS + 2) ? 2 * DATA_WIDTH + 2
                                                          : FRAC_BITS + 2;

  localparam logic signed [WW-1:0] MAX_W = WW'((PW'(1) << (DW - 1)) - PW'(1));
  localparam logic signed [WW-1:0] MIN_W = ~MAX_W;
  localparam logic signed [WW-1:0] BIAS  = WW'(1) << (FRAC_BITS - 1);
  localparam logic signed [WW-1:0] ONE_W = WW'(1);

  function automatic logic signed [DW-1:0] sat_f(input logic signed [WW-1:0] x);
    logic signed [DW-1:0] r;
    if (x > MAX_W) begin
      r = MAX_W[DW-1:0];
    end else if (x < MIN_W) begin
      r = MIN_W[DW-1:0];
    end else begin
      r = x[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic clip_f(input logic signed [WW-1:0] x);
    return (x > MAX_W) || (x < MIN_W);
  endfunction

  // Round to nearest, ties toward plus infinity.
  function automatic logic signed [WW-1:0] rnd_f(input logic signed [PW-1:0] p);
    logic signed [WW-1:0] s;
    s = WW'(p) + BIAS;
    return s >>> FRAC_BITS;
  endfunction

  // Stage handshake.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || out_ch.ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // Stage 1: curl sums and the first saturated term.
  op_t                  op1_r;
  logic signed [DW-1:0] v1d_r, itg1_r, x1_r, ca1_r, cb1_r, cc1_r, cd1_r;
  logic signed [DW:0]   k1_r;
  logic                 clip1_r;

  logic signed [DW:0]   k1_nxt;
  logic signed [WW-1:0] hsum, hhalf, pre1;
  logic signed [DW-1:0] x1_nxt, itg1_nxt;

  always_comb begin
    k1_nxt = (DW+1)'(in_ch.neighbor_a) - (DW+1)'(in_ch.neighbor_b);
    hsum   = WW'(in_ch.neighbor_a) - WW'(in_ch.neighbor_b)
           - WW'(in_ch.neighbor_c) + WW'(in_ch.neighbor_d);
    hhalf  = (hsum + ONE_W) >>> 1;
    case (in_ch.operation)
      OP_DZ:   pre1 = hhalf;
      OP_EZ:   pre1 = WW'(in_ch.value_old) - WW'(in_ch.integral_old);
      default: pre1 = WW'(in_ch.integral_old) + WW'(k1_nxt);
    endcase
    x1_nxt   = sat_f(pre1);
    itg1_nxt = (in_ch.operation == OP_HX || in_ch.operation == OP_HY) ? x1_nxt
                                                                      : in_ch.integral_old;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op1_r   <= in_ch.operation;
      v1d_r   <= in_ch.value_old;
      itg1_r  <= itg1_nxt;
      x1_r    <= x1_nxt;
      k1_r    <= k1_nxt;
      ca1_r   <= in_ch.coef_a;
      cb1_r   <= in_ch.coef_b;
      cc1_r   <= in_ch.coef_c;
      cd1_r   <= in_ch.coef_d;
      clip1_r <= clip_f(pre1);
    end
  end

  // Stage 2: coefficient products, or the first product with the field.
  op_t                  op2_r;
  logic signed [DW-1:0] v2d_r, itg2_r, x2_r, ca2_r, cb2_r;
  logic signed [DW:0]   k2_r;
  logic signed [PW-1:0] m2a_r, m2b_r;
  logic                 clip2_r;
  logic signed [DW-1:0] ma2, mb2;

  always_comb begin
    ma2 = (op1_r == OP_HX || op1_r == OP_HY) ? cc1_r : ca1_r;
    mb2 = (op1_r == OP_DZ) ? cb1_r : x1_r;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      op2_r   <= op1_r;
      v2d_r   <= v1d_r;
      itg2_r  <= itg1_r;
      x2_r    <= x1_r;
      k2_r    <= k1_r;
      ca2_r   <= ca1_r;
      cb2_r   <= cb1_r;
      m2a_r   <= ma2 * mb2;
      m2b_r   <= cc1_r * cd1_r;
      clip2_r <= clip1_r;
    end
  end

  // Stage 3: round and saturate the first products.
  op_t                  op3_r;
  logic signed [DW-1:0] v3d_r, itg3_r, x3_r, ca3_r, cb3_r, y1_r, y2_r;
  logic                 clip3_r;
  logic signed [WW-1:0] r3a, r3b, khalf, pre3a;
  logic signed [DW-1:0] y1_nxt, y2_nxt;
  logic                 clip3_nxt;

  always_comb begin
    r3a   = rnd_f(m2a_r);
    r3b   = rnd_f(m2b_r);
    khalf = (WW'(k2_r) + ONE_W) >>> 1;
    pre3a = (op2_r == OP_HX || op2_r == OP_HY) ? khalf + r3a : r3a;
    y1_nxt = sat_f(pre3a);
    y2_nxt = sat_f(r3b);
    clip3_nxt = clip2_r || clip_f(pre3a) || ((op2_r == OP_DZ) && clip_f(r3b));
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      op3_r   <= op2_r;
      v3d_r   <= v2d_r;
      itg3_r  <= itg2_r;
      x3_r    <= x2_r;
      ca3_r   <= ca2_r;
      cb3_r   <= cb2_r;
      y1_r    <= y1_nxt;
      y2_r    <= y2_nxt;
      clip3_r <= clip3_nxt;
    end
  end

  // Stage 4: second products.
  op_t                  op4_r;
  logic signed [DW-1:0] itg4_r, y14_r;
  logic signed [PW-1:0] m4a_r, m4b_r;
  logic                 clip4_r;
  logic signed [DW-1:0] ma4, mb4, mc4, md4;

  always_comb begin
    case (op3_r)
      OP_DZ: begin
        ma4 = y1_r;
        mb4 = v3d_r;
        mc4 = y2_r;
        md4 = x3_r;
      end
      OP_EZ: begin
        ma4 = cb3_r;
        mb4 = y1_r;
        mc4 = cb3_r;
        md4 = y1_r;
      end
      default: begin
        ma4 = ca3_r;
        mb4 = v3d_r;
        mc4 = cb3_r;
        md4 = y1_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      op4_r   <= op3_r;
      itg4_r  <= itg3_r;
      y14_r   <= y1_r;
      m4a_r   <= ma4 * mb4;
      m4b_r   <= mc4 * md4;
      clip4_r <= clip3_r;
    end
  end

  // Stage 5: final sums into the output register.
  logic signed [DW-1:0] fld5_r, itg5_r;
  logic                 clip5_r;
  logic signed [WW-1:0] r5a, r5b, pre5f, pre5i;
  logic signed [DW-1:0] fld5_nxt, itg5_nxt;
  logic                 clip5_nxt;

  always_comb begin
    r5a   = rnd_f(m4a_r);
    r5b   = rnd_f(m4b_r);
    pre5f = (op4_r == OP_HY) ? r5a - r5b : r5a + r5b;
    pre5i = WW'(itg4_r) + r5a;
    if (op4_r == OP_EZ) begin
      fld5_nxt  = y14_r;
      itg5_nxt  = sat_f(pre5i);
      clip5_nxt = clip4_r || clip_f(pre5i);
    end else begin
      fld5_nxt  = sat_f(pre5f);
      itg5_nxt  = itg4_r;
      clip5_nxt = clip4_r || clip_f(pre5f);
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      fld5_r  <= fld5_nxt;
      itg5_r  <= itg5_nxt;
      clip5_r <= clip5_nxt;
    end
  end

  assign out_ch.valid        = v5_r;
  assign out_ch.field_new    = fld5_r;
  assign out_ch.integral_new = itg5_r;
  assign out_ch.saturated    = clip5_r;

endmodule

`default_nettype wire

@@ sim/fdtd_tmz_pml_cell_update_test.sv @@
`timescale 1ns / 1ps

module fdtd_tmz_pml_cell_update_test
  import fdtd_pkg::*;
;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 24;
  localparam int RANDOM_CELLS = 950;
  localparam int QUIET_TAIL = 120;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 48;
  localparam int STALL_LIMIT = 1000;

  typedef logic signed [DATA_WIDTH-1:0] q_t;
  typedef logic signed [127:0] wide_t;

  localparam q_t Q_ONE = q_t'(1) <<< FRAC_BITS;
  localparam q_t Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam wide_t ROUND_BIAS = wide_t'(1) <<< (FRAC_BITS - 1);
  localparam wide_t CLIP_HIGH = (wide_t'(1) <<< (DATA_WIDTH - 1)) - wide_t'(1);
  localparam wide_t CLIP_LOW = -(wide_t'(1) <<< (DATA_WIDTH - 1));

  typedef struct {
    op_t operation;
    q_t  value_old;
    q_t  integral_old;
    q_t  neighbor_a;
    q_t  neighbor_b;
    q_t  neighbor_c;
    q_t  neighbor_d;
    q_t  coef_a;
    q_t  coef_b;
    q_t  coef_c;
    q_t  coef_d;
  } cell_item_t;

  typedef struct {
    q_t   field_new;
    q_t   integral_new;
    logic saturated;
  } cell_result_t;

  logic clk;
  logic rst_n;

  fdtd_in_if  #(.DATA_WIDTH(DATA_WIDTH)) in_ch ();
  fdtd_out_if #(.DATA_WIDTH(DATA_WIDTH)) out_ch ();

  fdtd_tmz_pml_cell_update #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  cell_item_t   pending_cells[$];
  cell_result_t expected_results[$];

  bit in_took;
  bit hold_done;
  int send_gap;
  int stall_left;
  int hold_left;
  int idle_cycles;
  int mismatches;
  int cells_accepted;
  int results_checked;
  int clipped_results;
  int op_seen[4];

  // Fixed-point helpers: round to nearest with ties toward +infinity, and
  // clipping to the signed data range that flags any clip.
  function automatic wide_t round_q(input wide_t p);
    return (p + ROUND_BIAS) >>> FRAC_BITS;
  endfunction

  function automatic wide_t halve(input wide_t x);
    return (x + wide_t'(1)) >>> 1;
  endfunction

  function automatic wide_t clip(input wide_t x, inout bit hit);
    if (x > CLIP_HIGH) begin
      hit = 1'b1;
      return CLIP_HIGH;
    end
    if (x < CLIP_LOW) begin
      hit = 1'b1;
      return CLIP_LOW;
    end
    return x;
  endfunction

  function automatic cell_result_t predict_cell(input cell_item_t c);
    cell_result_t r;
    bit    hit;
    wide_t v, ig, na, nb, nc, nd, ca, cb, cc, cd;
    wide_t g3, g2, h, d, k, inner, t, prod, fld, itg;
    hit = 1'b0;
    v  = c.value_old;
    ig = c.integral_old;
    na = c.neighbor_a;
    nb = c.neighbor_b;
    nc = c.neighbor_c;
    nd = c.neighbor_d;
    ca = c.coef_a;
    cb = c.coef_b;
    cc = c.coef_c;
    cd = c.coef_d;
    case (c.operation)
      OP_DZ: begin
        g3  = clip(round_q(ca * cb), hit);
        g2  = clip(round_q(cc * cd), hit);
        h   = clip(halve(na - nb - nc + nd), hit);
        fld = clip(round_q(g3 * v) + round_q(g2 * h), hit);
        itg = ig;
      end
      OP_EZ: begin
        d   = clip(v - ig, hit);
        fld = clip(round_q(ca * d), hit);
        itg = clip(ig + round_q(cb * fld), hit);
      end
      default: begin
        k     = na - nb;
        itg   = clip(ig + k, hit);
        inner = clip(halve(k) + round_q(cc * itg), hit);
        t     = round_q(cb * inner);
        prod  = round_q(ca * v);
        if (c.operation == OP_HX) begin
          fld = clip(prod + t, hit);
        end else begin
          fld = clip(prod - t, hit);
        end
      end
    endcase
    r.field_new    = fld[DATA_WIDTH-1:0];
    r.integral_new = itg[DATA_WIDTH-1:0];
    r.saturated    = hit;
    return r;
  endfunction

  task automatic add_cell(input op_t op, input q_t v, input q_t ig, input q_t na,
                          input q_t nb, input q_t nc, input q_t nd, input q_t ca,
                          input q_t cb, input q_t cc, input q_t cd);
    cell_item_t c;
    c = '{op, v, ig, na, nb, nc, nd, ca, cb, cc, cd};
    pending_cells.push_back(c);
  endtask

  // Field values of the size a real grid carries: sixteen units or less.
  function automatic q_t field_q();
    q_t r;
    r = q_t'($urandom());
    return r >>> $urandom_range(3, 14);
  endfunction

  // PML and material factors mostly sit between zero and two.
  function automatic q_t coef_q();
    q_t r;
    r = q_t'($urandom_range(0, 2 << FRAC_BITS));
    if ($urandom_range(0, 7) == 0) begin
      r = -r;
    end
    return r;
  endfunction

  function automatic q_t extreme_q(input q_t keep);
    case ($urandom_range(0, 3))
      0: return Q_MAX;
      1: return Q_MIN;
      default: return keep;
    endcase
  endfunction

  function automatic cell_item_t random_cell();
    cell_item_t c;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    c.operation = op_t'($urandom_range(0, 3));
    if (kind < 2) begin
      c.value_old    = q_t'($urandom());
      c.integral_old = q_t'($urandom());
      c.neighbor_a   = q_t'($urandom());
      c.neighbor_b   = q_t'($urandom());
      c.neighbor_c   = q_t'($urandom());
      c.neighbor_d   = q_t'($urandom());
      c.coef_a       = q_t'($urandom());
      c.coef_b       = q_t'($urandom());
      c.coef_c       = q_t'($urandom());
      c.coef_d       = q_t'($urandom());
    end else begin
      c.value_old    = field_q();
      c.integral_old = field_q();
      c.neighbor_a   = field_q();
      c.neighbor_b   = field_q();
      c.neighbor_c   = field_q();
      c.neighbor_d   = field_q();
      c.coef_a       = coef_q();
      c.coef_b       = coef_q();
      c.coef_c       = coef_q();
      c.coef_d       = coef_q();
      // Occasionally push some operands to the edge of the range.
      if (kind == 9) begin
        c.value_old    = extreme_q(c.value_old);
        c.integral_old = extreme_q(c.integral_old);
        c.neighbor_a   = extreme_q(c.neighbor_a);
        c.neighbor_b   = extreme_q(c.neighbor_b);
        c.coef_a       = extreme_q(c.coef_a);
        c.coef_b       = extreme_q(c.coef_b);
      end
    end
    return c;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: a new item goes out at the falling edge after the previous one
  // was taken, unless a random gap is due.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_cells.size() != 0) begin
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= pending_cells[0].operation;
        in_ch.value_old    <= pending_cells[0].value_old;
        in_ch.integral_old <= pending_cells[0].integral_old;
        in_ch.neighbor_a   <= pending_cells[0].neighbor_a;
        in_ch.neighbor_b   <= pending_cells[0].neighbor_b;
        in_ch.neighbor_c   <= pending_cells[0].neighbor_c;
        in_ch.neighbor_d   <= pending_cells[0].neighbor_d;
        in_ch.coef_a       <= pending_cells[0].coef_a;
        in_ch.coef_b       <= pending_cells[0].coef_b;
        in_ch.coef_c       <= pending_cells[0].coef_c;
        in_ch.coef_d       <= pending_cells[0].coef_d;
        void'(pending_cells.pop_front());
        if (pending_cells.size() > QUIET_TAIL && $urandom_range(0, 6) == 0) begin
          send_gap = $urandom_range(1, 4);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: short random stalls, plus one long hold-off that lets the
  // pipeline fill and push back on the input.
  always @(negedge clk) begin
    if (!hold_done && cells_accepted >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (pending_cells.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cell_item_t   seen;
    cell_result_t want;
    in_took <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (out_ch.saturated === 1'b1) begin
        clipped_results++;
      end
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected: field_new %0d", out_ch.field_new);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.field_new !== want.field_new) begin
          $error("field_new: expected %0d, actual %0d", want.field_new, out_ch.field_new);
          mismatches++;
        end
        if (out_ch.integral_new !== want.integral_new) begin
          $error("integral_new: expected %0d, actual %0d",
                 want.integral_new, out_ch.integral_new);
          mismatches++;
        end
        if (out_ch.saturated !== want.saturated) begin
          $error("saturated: expected %0b, actual %0b", want.saturated, out_ch.saturated);
          mismatches++;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen.operation    = in_ch.operation;
      seen.value_old    = in_ch.value_old;
      seen.integral_old = in_ch.integral_old;
      seen.neighbor_a   = in_ch.neighbor_a;
      seen.neighbor_b   = in_ch.neighbor_b;
      seen.neighbor_c   = in_ch.neighbor_c;
      seen.neighbor_d   = in_ch.neighbor_d;
      seen.coef_a       = in_ch.coef_a;
      seen.coef_b       = in_ch.coef_b;
      seen.coef_c       = in_ch.coef_c;
      seen.coef_d       = in_ch.coef_d;
      expected_results.push_back(predict_cell(seen));
      cells_accepted++;
      op_seen[seen.operation]++;
    end
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("fdtd_tmz_pml_cell_update_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_DZ;
    in_ch.value_old    = '0;
    in_ch.integral_old = '0;
    in_ch.neighbor_a   = '0;
    in_ch.neighbor_b   = '0;
    in_ch.neighbor_c   = '0;
    in_ch.neighbor_d   = '0;
    in_ch.coef_a       = '0;
    in_ch.coef_b       = '0;
    in_ch.coef_c       = '0;
    in_ch.coef_d       = '0;
    out_ch.ready       = 1'b0;

    // Every operation with all operands zero, all at the top and all at the
    // bottom of the range.
    add_cell(OP_DZ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_cell(OP_EZ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_cell(OP_HX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_cell(OP_HY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_cell(OP_DZ, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    add_cell(OP_EZ, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    add_cell(OP_HX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    add_cell(OP_HY, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    add_cell(OP_DZ, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    add_cell(OP_EZ, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    add_cell(OP_HX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    add_cell(OP_HY, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    // The Dz update must pass the integral through untouched.
    add_cell(OP_DZ, Q_ONE, q_t'($urandom()), Q_ONE, 0, Q_ONE >>> 1, 0,
             Q_ONE, Q_ONE, Q_ONE >>> 1, Q_ONE);
    // Rounding ties, positive and negative, in a product and in the halving.
    add_cell(OP_EZ, 1, 0, 0, 0, 0, 0, Q_ONE >>> 1, 0, 0, 0);
    add_cell(OP_EZ, -1, 0, 0, 0, 0, 0, Q_ONE >>> 1, 0, 0, 0);
    add_cell(OP_HX, 0, 0, 1, 0, 0, 0, 0, Q_ONE, 0, 0);
    add_cell(OP_HY, 0, 0, -1, 0, 0, 0, 0, Q_ONE, 0, 0);
    // Clipping in an intermediate sum of each operation.
    add_cell(OP_HY, Q_ONE, Q_MAX, Q_ONE, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE, 0);
    add_cell(OP_HX, Q_ONE, Q_MIN, Q_MIN, Q_MAX, 0, 0, Q_ONE, Q_ONE, Q_ONE, 0);
    add_cell(OP_DZ, Q_ONE, 0, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    add_cell(OP_EZ, Q_MAX, Q_MIN, 0, 0, 0, 0, Q_ONE, Q_ONE, 0, 0);
    // Ordinary unit-scale updates of the magnetic field.
    add_cell(OP_HX, Q_ONE, Q_ONE >>> 3, Q_ONE <<< 1, -Q_ONE, 0, 0,
             Q_ONE, Q_ONE >>> 1, Q_ONE >>> 2, 0);
    add_cell(OP_HY, -Q_ONE, -(Q_ONE >>> 3), -Q_ONE, Q_ONE, 0, 0,
             Q_ONE, Q_ONE >>> 1, Q_ONE >>> 2, 0);
    for (int n = 0; n < RANDOM_CELLS; n++) begin
      pending_cells.push_back(random_cell());
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cells.size() != 0 || in_ch.valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("covered %0d cells (dz %0d, ez %0d, hx %0d, hy %0d), %0d results checked",
             cells_accepted, op_seen[OP_DZ], op_seen[OP_EZ], op_seen[OP_HX],
             op_seen[OP_HY], results_checked);
    $display("%0d results clipped, one long output stall of %0d cycles",
             clipped_results, HOLD_CYCLES);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("fdtd_tmz_pml_cell_update_test: PASS");
    end else begin
      $display("fdtd_tmz_pml_cell_update_test: FAIL");
    end
    $finish;
  end

endmodule
